@@ hdl/tfcc_pkg.sv @@
// Package for the text format checker: item and configuration types, register
// indexes, check kinds and the think tag character tables.
// No dependencies.
package tfcc_pkg;

    localparam int DEPTH_BITS_DEF  = 16;
    localparam int LENGTH_BITS_DEF = 16;
    localparam int PREFIX_MAX_DEF  = 8;

    localparam int LIMIT_W     = 16;
    localparam int PREFIX_W    = 64;
    localparam int PLEN_W      = 4;
    localparam int KIND_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_KIND    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_BYTES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LENGTH = 2'd3;

    localparam logic [KIND_W-1:0] KIND_JSON    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_THINK   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MAX_LEN = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MIN_LEN = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PREFIX  = 3'd4;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LT     = 8'h3C;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       has;
        logic       last;
        logic       is_zero;
        logic       is_ws;
        logic       is_open;
        logic       is_close;
        logic       is_quote;
        logic       is_bslash;
        logic       is_lt;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0]   check_kind;
        logic [LIMIT_W-1:0]  length_limit;
        logic [PREFIX_W-1:0] prefix_bytes;
        logic [PLEN_W-1:0]   prefix_length;
    } cfg_t;

    function automatic logic [7:0] open_tag_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0: c = 8'h3C;
            3'd1: c = 8'h74;
            3'd2: c = 8'h68;
            3'd3: c = 8'h69;
            3'd4: c = 8'h6E;
            3'd5: c = 8'h6B;
            3'd6: c = 8'h3E;
            default: c = 8'h3C;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] close_tag_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0: c = 8'h3C;
            3'd1: c = 8'h2F;
            3'd2: c = 8'h74;
            3'd3: c = 8'h68;
            3'd4: c = 8'h69;
            3'd5: c = 8'h6E;
            3'd6: c = 8'h6B;
            3'd7: c = 8'h3E;
        endcase
        return c;
    endfunction

endpackage

@@ hdl/text_format_constraint_checker.sv @@
// Top level of the text format checker: configuration registers and the
// front end, queue and back end. Depends on tfcc_pkg, tfcc_front, tfcc_queue, tfcc_back.
//
//   Channel   Handshake           Payload
//   input     push / full         text_byte, has_byte, last_byte
//   result    empty / pop         passed
//   config    cfg_we              cfg_index, cfg_wdata
//
// One request per cycle is taken while the queue is not full; each request is
// registered in the queue, and the back end updates the string state from the
// queue head and, for a last byte, loads the verdict into the result register.
// A result waits in a single output register; while it is held, bytes keep
// flowing and only a following last byte stalls in the four-entry queue.
// Reset clears the string state, the queue and the configuration registers.
module text_format_constraint_checker
#(
    parameter int DEPTH_BITS  = tfcc_pkg::DEPTH_BITS_DEF,
    parameter int LENGTH_BITS = tfcc_pkg::LENGTH_BITS_DEF,
    parameter int PREFIX_MAX  = tfcc_pkg::PREFIX_MAX_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     text_byte,
    input  logic                           has_byte,
    input  logic                           last_byte,
    output logic                           empty,
    input  logic                           pop,
    output logic                           passed,
    input  logic                           cfg_we,
    input  logic [tfcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tfcc_pkg::PREFIX_W-1:0]  cfg_wdata
);

    tfcc_pkg::cfg_t  cfg_reg, cfg_next;
    tfcc_pkg::item_t fe_item;
    tfcc_pkg::item_t q_head;
    logic            fe_push;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                tfcc_pkg::CFG_CHECK_KIND:
                    cfg_next.check_kind = cfg_wdata[tfcc_pkg::KIND_W-1:0];
                tfcc_pkg::CFG_LENGTH_LIMIT:
                    cfg_next.length_limit = cfg_wdata[tfcc_pkg::LIMIT_W-1:0];
                tfcc_pkg::CFG_PREFIX_BYTES:
                    cfg_next.prefix_bytes = cfg_wdata;
                tfcc_pkg::CFG_PREFIX_LENGTH:
                    cfg_next.prefix_length = cfg_wdata[tfcc_pkg::PLEN_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    tfcc_front u_front
    (
        .push      (push),
        .full      (full),
        .text_byte (text_byte),
        .has_byte  (has_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .q_push    (fe_push),
        .q_item    (fe_item)
    );

    tfcc_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fe_push),
        .wr_item (fe_item),
        .rd_en   (q_pop),
        .rd_item (q_head),
        .full    (q_full),
        .empty   (q_empty)
    );

    tfcc_back
    #(
        .DEPTH_BITS  (DEPTH_BITS),
        .LENGTH_BITS (LENGTH_BITS),
        .PREFIX_MAX  (PREFIX_MAX)
    )
    u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_item  (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .passed  (passed)
    );

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("back end drained an empty queue");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_head.last && !empty && !pop))
        else $error("result overwritten before it was taken");

    a_last_makes_result: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && q_head.last) |=> !empty)
        else $error("last request did not produce a result");

    a_full_has_entries: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !q_empty)
        else $error("queue reports full and empty together");

endmodule

@@ hdl/tfcc_front.sv @@
// Front end: takes requests from the input channel and classifies each byte.
// Depends on tfcc_pkg; feeds tfcc_queue.
module tfcc_front
(
    input  logic            push,
    output logic            full,
    input  logic [7:0]      text_byte,
    input  logic            has_byte,
    input  logic            last_byte,
    input  logic            q_full,
    output logic            q_push,
    output tfcc_pkg::item_t q_item
);

    assign full   = q_full;
    assign q_push = push && !q_full;

    always_comb
    begin
        q_item           = '0;
        q_item.byte_val  = text_byte;
        q_item.has       = has_byte;
        q_item.last      = last_byte;
        q_item.is_zero   = (text_byte == 8'h00);
        q_item.is_ws     = (text_byte == tfcc_pkg::CH_SPACE) || (text_byte == tfcc_pkg::CH_TAB)
                        || (text_byte == tfcc_pkg::CH_LF) || (text_byte == tfcc_pkg::CH_CR);
        q_item.is_open   = (text_byte == tfcc_pkg::CH_LBRACE)
                        || (text_byte == tfcc_pkg::CH_LBRACK);
        q_item.is_close  = (text_byte == tfcc_pkg::CH_RBRACE)
                        || (text_byte == tfcc_pkg::CH_RBRACK);
        q_item.is_quote  = (text_byte == tfcc_pkg::CH_QUOTE);
        q_item.is_bslash = (text_byte == tfcc_pkg::CH_BSLASH);
        q_item.is_lt     = (text_byte == tfcc_pkg::CH_LT);
    end

endmodule

@@ hdl/tfcc_queue.sv @@
// Short queue of classified requests between the front end and the back end.
// Depends on tfcc_pkg.
module tfcc_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  tfcc_pkg::item_t wr_item,
    input  logic            rd_en,
    output tfcc_pkg::item_t rd_item,
    output logic            full,
    output logic            empty
);

    tfcc_pkg::item_t                 entry_reg [tfcc_pkg::QUEUE_DEPTH];
    logic [tfcc_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [tfcc_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [tfcc_pkg::QPTR_W:0]       count_reg, count_next;

    assign full    = (count_reg == (tfcc_pkg::QPTR_W + 1)'(tfcc_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + (tfcc_pkg::QPTR_W)'(wr_en);
        rd_ptr_next = rd_ptr_reg + (tfcc_pkg::QPTR_W)'(rd_en);
        count_next  = count_reg + (tfcc_pkg::QPTR_W + 1)'(wr_en)
                    - (tfcc_pkg::QPTR_W + 1)'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

@@ hdl/tfcc_back.sv @@
// Back end: per-string checking state, verdict and the result register.
// Depends on tfcc_pkg; drains tfcc_queue.
module tfcc_back
#(
    parameter int DEPTH_BITS  = tfcc_pkg::DEPTH_BITS_DEF,
    parameter int LENGTH_BITS = tfcc_pkg::LENGTH_BITS_DEF,
    parameter int PREFIX_MAX  = tfcc_pkg::PREFIX_MAX_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  tfcc_pkg::cfg_t  cfg,
    input  tfcc_pkg::item_t q_item,
    input  logic            q_empty,
    output logic            q_pop,
    input  logic            pop,
    output logic            empty,
    output logic            passed
);

    localparam int CNT_W = LENGTH_BITS + 1;

    typedef struct packed {
        logic                  leading_done;
        logic                  start_good;
        logic [DEPTH_BITS-1:0] nest_depth;
        logic                  inside_quote;
        logic                  escape_pending;
        logic                  mark_seen;
        logic                  balance_broken;
        logic [2:0]            open_tag_progress;
        logic [2:0]            close_tag_progress;
        logic                  open_tag_found;
        logic [1:0]            close_tag_count;
        logic                  tag_order_bad;
        logic [CNT_W-1:0]      byte_count;
        logic                  prefix_mismatch;
        logic                  string_ended;
    } str_state_t;

    str_state_t state_reg, state_next;
    str_state_t upd;
    logic       res_valid_reg, res_valid_next;
    logic       passed_reg, passed_next;
    logic       verdict;
    logic [tfcc_pkg::PLEN_W-1:0] plen_eff;
    logic [7:0] prefix_byte;

    assign empty  = !res_valid_reg;
    assign passed = passed_reg;
    assign q_pop  = !q_empty && (!q_item.last || !res_valid_reg || pop);

    assign plen_eff = (cfg.prefix_length > (tfcc_pkg::PLEN_W)'(PREFIX_MAX))
                    ? (tfcc_pkg::PLEN_W)'(PREFIX_MAX) : cfg.prefix_length;

    always_comb
    begin
        upd = state_reg;
        if (q_item.has && !state_reg.string_ended)
        begin
            if (q_item.is_zero)
            begin
                upd.string_ended = 1'b1;
            end
            else
            begin
                if (!state_reg.leading_done && !q_item.is_ws)
                begin
                    upd.leading_done = 1'b1;
                    upd.start_good   = q_item.is_open;
                end

                if (state_reg.inside_quote)
                begin
                    priority if (state_reg.escape_pending)
                        upd.escape_pending = 1'b0;
                    else if (q_item.is_bslash)
                        upd.escape_pending = 1'b1;
                    else if (q_item.is_quote)
                        upd.inside_quote = 1'b0;
                    else
                        upd.inside_quote = 1'b1;
                end
                else if (q_item.is_quote)
                begin
                    upd.inside_quote = 1'b1;
                    upd.mark_seen    = 1'b1;
                end
                else if (q_item.is_open)
                begin
                    upd.mark_seen = 1'b1;
                    if (&state_reg.nest_depth)
                        upd.balance_broken = 1'b1;
                    else
                        upd.nest_depth = state_reg.nest_depth + DEPTH_BITS'(1);
                end
                else if (q_item.is_close)
                begin
                    upd.mark_seen = 1'b1;
                    if (state_reg.nest_depth == '0)
                        upd.balance_broken = 1'b1;
                    else
                        upd.nest_depth = state_reg.nest_depth - DEPTH_BITS'(1);
                end

                if (q_item.byte_val == tfcc_pkg::open_tag_char(state_reg.open_tag_progress))
                begin
                    if (state_reg.open_tag_progress == 3'd6)
                    begin
                        upd.open_tag_progress = '0;
                        upd.open_tag_found    = 1'b1;
                    end
                    else
                    begin
                        upd.open_tag_progress = state_reg.open_tag_progress + 3'd1;
                    end
                end
                else
                begin
                    upd.open_tag_progress = {2'b00, q_item.is_lt};
                end

                if (q_item.byte_val == tfcc_pkg::close_tag_char(state_reg.close_tag_progress))
                begin
                    upd.close_tag_progress = state_reg.close_tag_progress + 3'd1;
                    if (state_reg.close_tag_progress == 3'd7)
                    begin
                        if (state_reg.close_tag_count == 2'd0 && !state_reg.open_tag_found)
                            upd.tag_order_bad = 1'b1;
                        if (state_reg.close_tag_count != 2'd2)
                            upd.close_tag_count = state_reg.close_tag_count + 2'd1;
                    end
                end
                else
                begin
                    upd.close_tag_progress = {2'b00, q_item.is_lt};
                end

                if ((state_reg.byte_count < CNT_W'(plen_eff))
                    && (q_item.byte_val
                        != 8'(cfg.prefix_bytes >> {state_reg.byte_count[2:0], 3'b000})))
                    upd.prefix_mismatch = 1'b1;

                if (!state_reg.byte_count[LENGTH_BITS])
                    upd.byte_count = state_reg.byte_count + CNT_W'(1);
            end
        end
    end

    assign prefix_byte = 8'(cfg.prefix_bytes >> {upd.byte_count[2:0], 3'b000});

    always_comb
    begin
        unique case (cfg.check_kind)
            tfcc_pkg::KIND_JSON:
                verdict = upd.start_good && upd.mark_seen && (upd.nest_depth == '0)
                       && !upd.inside_quote && !upd.balance_broken;
            tfcc_pkg::KIND_THINK:
                verdict = upd.open_tag_found && (upd.close_tag_count == 2'd1)
                       && !upd.tag_order_bad;
            tfcc_pkg::KIND_MAX_LEN:
                verdict = ({{tfcc_pkg::LIMIT_W{1'b0}}, upd.byte_count}
                          <= {{CNT_W{1'b0}}, cfg.length_limit});
            tfcc_pkg::KIND_MIN_LEN:
                verdict = ({{tfcc_pkg::LIMIT_W{1'b0}}, upd.byte_count}
                          >= {{CNT_W{1'b0}}, cfg.length_limit});
            tfcc_pkg::KIND_PREFIX:
                verdict = !upd.prefix_mismatch
                       && ((upd.byte_count >= CNT_W'(plen_eff)) || (prefix_byte == 8'h00));
            default:
                verdict = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg && !pop;
        passed_next    = passed_reg;
        if (q_pop)
        begin
            if (q_item.last)
            begin
                state_next     = '0;
                res_valid_next = 1'b1;
                passed_next    = verdict;
            end
            else
            begin
                state_next = upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        passed_reg <= passed_next;
    end

endmodule
